// ===== design/frm_pkg.sv =====
`default_nettype none

package frm_pkg;

  // fixed field widths
  localparam int COMP_W = 32;
  localparam int PROD_W = 64;
  localparam int MAG_W  = 63;
  localparam int NRM_W  = 30;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int CFG_W  = 63;
  localparam int IDX_W  = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_Z_NEAR_ZERO  = 2'd0;
  localparam logic [IDX_W-1:0] REG_Z_SUBSTITUTE = 2'd1;
  localparam logic [IDX_W-1:0] REG_XY_SQ_LIMIT  = 2'd2;

  // branch codes
  localparam logic [1:0] CASE_GENERAL = 2'd0;
  localparam logic [1:0] CASE_Z_SUB   = 2'd1;
  localparam logic [1:0] CASE_HELPER  = 2'd2;

  typedef logic [2:0][COMP_W-1:0] vec32_t;
  typedef logic [2:0][PROD_W-1:0] vec64_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } axis_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
    logic [1:0]         case_taken;
    logic               degenerate;
  } frame_t;

  // side information that rides along the first normalization
  typedef struct packed {
    vec32_t      axis;
    logic [31:0] mod_z;
    logic [1:0]  kind;
  } head_sb_t;

  // side information for the later stages
  typedef struct packed {
    vec32_t     vec;
    logic [1:0] kind;
    logic       ok;
  } stage_sb_t;

endpackage

`default_nettype wire

// ===== design/frm_cross.sv =====
`default_nettype none

module frm_cross import frm_pkg::*; #(
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire vec32_t        a,
  input  wire vec32_t        b,
  input  wire logic [SW-1:0] in_sb,
  output logic               out_valid,
  output vec64_t             c,
  output logic [SW-1:0]      out_sb
);

  logic signed [PROD_W-1:0] p [0:5];
  logic                     v1;
  logic [SW-1:0]            sb1;

  // product halved with truncation toward zero
  function automatic logic signed [PROD_W-1:0] half_tz(input logic signed [PROD_W-1:0] x);
    half_tz = $signed(x + PROD_W'(x[PROD_W-1])) >>> 1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= $signed(a[1]) * $signed(b[2]);
      p[1] <= $signed(a[2]) * $signed(b[1]);
      p[2] <= $signed(a[2]) * $signed(b[0]);
      p[3] <= $signed(a[0]) * $signed(b[2]);
      p[4] <= $signed(a[0]) * $signed(b[1]);
      p[5] <= $signed(a[1]) * $signed(b[0]);
      sb1  <= in_sb;
      c[0]   <= half_tz(p[0]) - half_tz(p[1]);
      c[1]   <= half_tz(p[2]) - half_tz(p[3]);
      c[2]   <= half_tz(p[4]) - half_tz(p[5]);
      out_sb <= sb1;
    end
  end

endmodule

`default_nettype wire

// ===== design/frm_sqrt_cell.sv =====
`default_nettype none

module frm_sqrt_cell import frm_pkg::*; #(
  parameter int BIT = 0,
  parameter int PW  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  in_rem,
  input  wire logic [ROOT_W-1:0] in_root,
  input  wire logic [PW-1:0]     in_pass,
  output logic                   out_valid,
  output logic [SUM_W-1:0]       out_rem,
  output logic [ROOT_W-1:0]      out_root,
  output logic [PW-1:0]          out_pass
);

  logic [63:0] trial;
  logic        take;

  // (root + b)^2 - root^2 with b = 2^BIT
  assign trial = (64'(in_root) << (BIT + 1)) + (64'(1) << (2 * BIT));
  assign take  = 64'(in_rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem  <= take ? SUM_W'(64'(in_rem) - trial) : in_rem;
      out_root <= take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
      out_pass <= in_pass;
    end
  end

endmodule

`default_nettype wire

// ===== design/frm_div_cell.sv =====
`default_nettype none

module frm_div_cell import frm_pkg::*; #(
  parameter int BIT   = 0,
  parameter int NUM_W = 61,
  parameter int Q_W   = 31,
  parameter int PW    = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire logic                   in_valid,
  input  wire logic [2:0][NUM_W-1:0]  in_rem,
  input  wire logic [2:0][Q_W-1:0]    in_quo,
  input  wire logic [ROOT_W-1:0]      in_den,
  input  wire logic [PW-1:0]          in_pass,
  output logic                        out_valid,
  output logic [2:0][NUM_W-1:0]       out_rem,
  output logic [2:0][Q_W-1:0]         out_quo,
  output logic [ROOT_W-1:0]           out_den,
  output logic [PW-1:0]               out_pass
);

  logic [NUM_W-1:0] dsh;

  assign dsh = NUM_W'(in_den) << BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (in_rem[i] >= dsh) begin
          out_rem[i] <= in_rem[i] - dsh;
          out_quo[i] <= in_quo[i] | (Q_W'(1) << BIT);
        end else begin
          out_rem[i] <= in_rem[i];
          out_quo[i] <= in_quo[i];
        end
      end
      out_den  <= in_den;
      out_pass <= in_pass;
    end
  end

endmodule

`default_nettype wire

// ===== design/frm_norm.sv =====
`default_nettype none

module frm_norm import frm_pkg::*; #(
  parameter int FRAC_BITS = 30,
  parameter int SW        = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire vec64_t        v,
  input  wire logic [SW-1:0] in_sb,
  output logic               out_valid,
  output vec32_t             r,
  output logic               out_ok,
  output logic [SW-1:0]      out_sb
);

  localparam int Q_W   = FRAC_BITS + 1;
  localparam int NUM_W = NRM_W + FRAC_BITS + 1;
  localparam int CW    = SW + 4;
  localparam int SPW   = CW + 3 * NRM_W;
  localparam int NSH   = 6;

  // ctl = {sb, ok, neg[2:0]}
  logic                  v0;
  logic [2:0][MAG_W-1:0] mag0;
  logic [2:0]            neg0;
  logic [SW-1:0]         sb0;

  logic                  sh_v   [0:NSH];
  logic [2:0][MAG_W-1:0] sh_mag [0:NSH];
  logic [MAG_W-1:0]      sh_mx  [0:NSH];
  logic [CW-1:0]         sh_ctl [0:NSH];

  logic                  vq;
  logic [2:0][NRM_W-1:0] nq;
  logic [2:0][59:0]      sq;
  logic [CW-1:0]         ctlq;

  logic                  vs;
  logic [2:0][NRM_W-1:0] ns;
  logic [SUM_W-1:0]      ssum;
  logic [CW-1:0]         ctls;

  logic                  rt_v    [0:ROOT_W];
  logic [SUM_W-1:0]      rt_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]     rt_root [0:ROOT_W];
  logic [SPW-1:0]        rt_pass [0:ROOT_W];

  logic                  dv_v    [0:Q_W];
  logic [2:0][NUM_W-1:0] dv_rem  [0:Q_W];
  logic [2:0][Q_W-1:0]   dv_quo  [0:Q_W];
  logic [ROOT_W-1:0]     dv_den  [0:Q_W];
  logic [CW-1:0]         dv_pass [0:Q_W];

  logic [2:0][NRM_W-1:0] rt_n;
  logic [ROOT_W-1:0]     m;
  logic [2:0]            fin_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      sh_v[0]  <= 1'b0;
      vq       <= 1'b0;
      vs       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= in_valid;
      sh_v[0]   <= v0;
      vq        <= sh_v[NSH];
      vs        <= vq;
      out_valid <= dv_v[Q_W];
    end
  end

  // magnitudes, then the largest of them
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg0[i] <= v[i][PROD_W-1];
        mag0[i] <= v[i][PROD_W-1] ? MAG_W'(-$signed(v[i])) : MAG_W'(v[i]);
      end
      sb0 <= in_sb;
      sh_mag[0] <= mag0;
      if (mag0[0] >= mag0[1] && mag0[0] >= mag0[2]) begin
        sh_mx[0] <= mag0[0];
      end else if (mag0[1] >= mag0[2]) begin
        sh_mx[0] <= mag0[1];
      end else begin
        sh_mx[0] <= mag0[2];
      end
      sh_ctl[0] <= {sb0, (mag0 != '0), neg0};
    end
  end

  // left-justify the group so the largest has its top bit set
  for (genvar j = 0; j < NSH; j++) begin : g_shift
    localparam int K = 32 >> j;
    logic do_sh;
    assign do_sh = (sh_mx[j][MAG_W-1 -: K] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        sh_v[j+1] <= 1'b0;
      end else if (adv) begin
        sh_v[j+1] <= sh_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          sh_mag[j+1][i] <= do_sh ? (sh_mag[j][i] << K) : sh_mag[j][i];
        end
        sh_mx[j+1]  <= do_sh ? (sh_mx[j] << K) : sh_mx[j];
        sh_ctl[j+1] <= sh_ctl[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nq[i] <= sh_mag[NSH][i][MAG_W-1 -: NRM_W];
        sq[i] <= 60'(sh_mag[NSH][i][MAG_W-1 -: NRM_W]) * 60'(sh_mag[NSH][i][MAG_W-1 -: NRM_W]);
      end
      ctlq <= sh_ctl[NSH];
      ns   <= nq;
      ssum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      ctls <= ctlq;
    end
  end

  assign rt_v[0]    = vs;
  assign rt_rem[0]  = ssum;
  assign rt_root[0] = '0;
  assign rt_pass[0] = {ctls, ns};

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    frm_sqrt_cell #(
      .BIT (ROOT_W - 1 - j),
      .PW  (SPW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (rt_v[j]),
      .in_rem   (rt_rem[j]),
      .in_root  (rt_root[j]),
      .in_pass  (rt_pass[j]),
      .out_valid(rt_v[j+1]),
      .out_rem  (rt_rem[j+1]),
      .out_root (rt_root[j+1]),
      .out_pass (rt_pass[j+1])
    );
  end

  assign rt_n = rt_pass[ROOT_W][3*NRM_W-1:0];
  assign m    = rt_root[ROOT_W];

  // rounded numerators for the three quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= rt_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NUM_W'(rt_n[i]) << FRAC_BITS) + NUM_W'(m >> 1);
      end
      dv_quo[0]  <= '0;
      dv_den[0]  <= m;
      dv_pass[0] <= rt_pass[ROOT_W][SPW-1 -: CW];
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    frm_div_cell #(
      .BIT   (Q_W - 1 - j),
      .NUM_W (NUM_W),
      .Q_W   (Q_W),
      .PW    (CW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (dv_v[j]),
      .in_rem   (dv_rem[j]),
      .in_quo   (dv_quo[j]),
      .in_den   (dv_den[j]),
      .in_pass  (dv_pass[j]),
      .out_valid(dv_v[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_quo  (dv_quo[j+1]),
      .out_den  (dv_den[j+1]),
      .out_pass (dv_pass[j+1])
    );
  end

  assign fin_neg = dv_pass[Q_W][2:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r[i] <= fin_neg[i] ? (32'(0) - 32'(dv_quo[Q_W][i])) : 32'(dv_quo[Q_W][i]);
      end
      out_ok <= dv_pass[Q_W][3];
      out_sb <= dv_pass[Q_W][CW-1:4];
    end
  end

endmodule

`default_nettype wire

// ===== design/orthonormal_frame_from_axis.sv =====
`default_nettype none

// channel  direction  payload               handshake
// in       input      axis_t (axis x,y,z)   in_valid / in_ready
// out      output     frame_t               out_valid / out_ready
// cfg      input      cfg_index, cfg_data   cfg_valid / cfg_ready (always ready)
//
// one transaction per cycle while the pipe is not held; the pipe is built from three
// normalizers, each a row of 31 square-root cells and FRAC_BITS+1 divide cells
// the whole pipe advances together; it holds only while out_valid is high
// and out_ready is low, and in_ready follows that same condition
// synchronous reset clears the valid bits and loads the register defaults

module orthonormal_frame_from_axis import frm_pkg::*; #(
  parameter int FRAC_BITS = 30
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire axis_t            in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output frame_t                out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int HSW = $bits(head_sb_t);
  localparam int SSW = $bits(stage_sb_t);

  logic [30:0]      z_near_zero;
  logic [30:0]      z_substitute;
  logic [CFG_W-1:0] xy_sq_limit;

  logic adv;

  logic               v0, v1, v2;
  vec32_t             ax0, ax1, ax2;
  logic [PROD_W-1:0]  sqx1, sqy1;
  logic [COMP_W-1:0]  az_abs1;
  logic [31:0]        mod_z2;
  logic [1:0]         kind2;
  logic [PROD_W-1:0]  xy_sq;

  vec64_t    n1_in;
  head_sb_t  n1_sb_in, n1_sb_out;
  logic [HSW-1:0] n1_sb_raw;
  logic      n1_v, n1_ok;
  vec32_t    n1_r;

  vec32_t    helper, c1_a;
  stage_sb_t c1_sb_in, c1_sb_out;
  logic [SSW-1:0] c1_sb_raw;
  logic      c1_v;
  vec64_t    c1_c;

  stage_sb_t n2_sb_out;
  logic [SSW-1:0] n2_sb_raw;
  logic      n2_v, n2_ok;
  vec32_t    n2_r;

  stage_sb_t c2_sb_in, c2_sb_out;
  logic [SSW-1:0] c2_sb_raw;
  logic      c2_v;
  vec64_t    c2_c;

  stage_sb_t n3_sb_out;
  logic [SSW-1:0] n3_sb_raw;
  logic      n3_v, n3_ok;
  vec32_t    n3_r;

  logic      fin_ok;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_near_zero  <= 31'd107;
      z_substitute <= 31'd10737;
      xy_sq_limit  <= 63'd11529215046068;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_Z_NEAR_ZERO:  z_near_zero  <= cfg_data[30:0];
        REG_Z_SUBSTITUTE: z_substitute <= cfg_data[30:0];
        REG_XY_SQ_LIMIT:  xy_sq_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= n3_v;
    end
  end

  assign xy_sq = sqx1 + sqy1;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0[0] <= in_data.axis_x;
      ax0[1] <= in_data.axis_y;
      ax0[2] <= in_data.axis_z;

      ax1     <= ax0;
      sqx1    <= $signed(ax0[0]) * $signed(ax0[0]);
      sqy1    <= $signed(ax0[1]) * $signed(ax0[1]);
      az_abs1 <= ax0[2][31] ? (32'(0) - ax0[2]) : ax0[2];

      ax2 <= ax1;
      if (az_abs1 < 32'(z_near_zero)) begin
        kind2  <= CASE_Z_SUB;
        mod_z2 <= 32'(z_substitute);
      end else if (xy_sq < 64'(xy_sq_limit)) begin
        kind2  <= CASE_HELPER;
        mod_z2 <= ax1[2];
      end else begin
        kind2  <= CASE_GENERAL;
        mod_z2 <= ax1[2];
      end
    end
  end

  // helper direction from the xy part
  assign n1_in[0] = {{32{ax2[0][31]}}, ax2[0]};
  assign n1_in[1] = {{32{ax2[1][31]}}, ax2[1]};
  assign n1_in[2] = '0;
  assign n1_sb_in = '{axis: ax2, mod_z: mod_z2, kind: kind2};

  frm_norm #(.FRAC_BITS(FRAC_BITS), .SW(HSW)) u_norm_helper (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v2),
    .v        (n1_in),
    .in_sb    (HSW'(n1_sb_in)),
    .out_valid(n1_v),
    .r        (n1_r),
    .out_ok   (n1_ok),
    .out_sb   (n1_sb_raw)
  );

  assign n1_sb_out = head_sb_t'(n1_sb_raw);

  always_comb begin
    if (n1_sb_out.kind == CASE_HELPER) begin
      helper[0] = 32'(64'(1) << FRAC_BITS);
      helper[1] = 32'(64'(1) << FRAC_BITS);
      helper[2] = '0;
    end else begin
      helper = n1_r;
    end
    c1_a[0] = n1_sb_out.axis[0];
    c1_a[1] = n1_sb_out.axis[1];
    c1_a[2] = n1_sb_out.mod_z;
    c1_sb_in.vec  = n1_sb_out.axis;
    c1_sb_in.kind = n1_sb_out.kind;
    c1_sb_in.ok   = (n1_sb_out.kind == CASE_HELPER) || n1_ok;
  end

  frm_cross #(.SW(SSW)) u_cross_side (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (n1_v),
    .a        (c1_a),
    .b        (helper),
    .in_sb    (SSW'(c1_sb_in)),
    .out_valid(c1_v),
    .c        (c1_c),
    .out_sb   (c1_sb_raw)
  );

  assign c1_sb_out = stage_sb_t'(c1_sb_raw);

  frm_norm #(.FRAC_BITS(FRAC_BITS), .SW(SSW)) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (c1_v),
    .v        (c1_c),
    .in_sb    (SSW'(c1_sb_out)),
    .out_valid(n2_v),
    .r        (n2_r),
    .out_ok   (n2_ok),
    .out_sb   (n2_sb_raw)
  );

  assign n2_sb_out = stage_sb_t'(n2_sb_raw);

  always_comb begin
    c2_sb_in.vec  = n2_r;
    c2_sb_in.kind = n2_sb_out.kind;
    c2_sb_in.ok   = n2_sb_out.ok && n2_ok;
  end

  frm_cross #(.SW(SSW)) u_cross_third (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (n2_v),
    .a        (n2_r),
    .b        (n2_sb_out.vec),
    .in_sb    (SSW'(c2_sb_in)),
    .out_valid(c2_v),
    .c        (c2_c),
    .out_sb   (c2_sb_raw)
  );

  assign c2_sb_out = stage_sb_t'(c2_sb_raw);

  frm_norm #(.FRAC_BITS(FRAC_BITS), .SW(SSW)) u_norm_third (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (c2_v),
    .v        (c2_c),
    .in_sb    (SSW'(c2_sb_out)),
    .out_valid(n3_v),
    .r        (n3_r),
    .out_ok   (n3_ok),
    .out_sb   (n3_sb_raw)
  );

  assign n3_sb_out = stage_sb_t'(n3_sb_raw);
  assign fin_ok    = n3_sb_out.ok && n3_ok;

  // any zero-length step clears all six vector fields
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.side_x     <= fin_ok ? n3_sb_out.vec[0] : '0;
      out_data.side_y     <= fin_ok ? n3_sb_out.vec[1] : '0;
      out_data.side_z     <= fin_ok ? n3_sb_out.vec[2] : '0;
      out_data.third_x    <= fin_ok ? n3_r[0] : '0;
      out_data.third_y    <= fin_ok ? n3_r[1] : '0;
      out_data.third_z    <= fin_ok ? n3_r[2] : '0;
      out_data.case_taken <= n3_sb_out.kind;
      out_data.degenerate <= !fin_ok;
    end
  end

endmodule

`default_nettype wire

// ===== dv/frame_checker.sv =====
`default_nettype none

module frame_checker import frm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire axis_t            in_data,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire frame_t           out_data,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int FB = 30;

  typedef longint trip_t [3];

  longint unsigned lim_z, sub_z, lim_xy;
  frame_t frames_due [$];

  function automatic longint half_tz(longint p);
    return (p >= 0) ? (p >>> 1) : -((-p) >>> 1);
  endfunction

  function automatic trip_t cross3(trip_t a, trip_t b);
    trip_t r;
    r[0] = half_tz(a[1] * b[2]) - half_tz(a[2] * b[1]);
    r[1] = half_tz(a[2] * b[0]) - half_tz(a[0] * b[2]);
    r[2] = half_tz(a[0] * b[1]) - half_tz(a[1] * b[0]);
    return r;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // group shift so the largest magnitude sits in [2^29, 2^30), then divide by the root
  function automatic bit unit_vec(trip_t v, output trip_t r);
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned mx, s, m, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : v[i];
      if (mag[i] > mx) mx = mag[i];
      r[i] = 0;
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    m = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (m >> 1)) / m;
      r[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic frame_t build_frame(axis_t a);
    trip_t ax, md, xy, hp, c, sd, th;
    longint unsigned az, xy_sq;
    logic [1:0] kind;
    bit ok;
    frame_t f;
    ax[0] = a.axis_x;
    ax[1] = a.axis_y;
    ax[2] = a.axis_z;
    md = ax;
    xy[0] = ax[0];
    xy[1] = ax[1];
    xy[2] = 0;
    az = (ax[2] < 0) ? 64'd0 - longint'(ax[2]) : ax[2];
    xy_sq = longint'(ax[0] * ax[0]) + longint'(ax[1] * ax[1]);
    if (az < lim_z) begin
      kind = CASE_Z_SUB;
      md[2] = longint'(sub_z);
      ok = unit_vec(xy, hp);
    end else if (xy_sq < lim_xy) begin
      kind = CASE_HELPER;
      hp[0] = 64'sd1 << FB;
      hp[1] = 64'sd1 << FB;
      hp[2] = 0;
      ok = 1;
    end else begin
      kind = CASE_GENERAL;
      ok = unit_vec(xy, hp);
    end
    sd = '{0, 0, 0};
    th = '{0, 0, 0};
    if (ok) ok = unit_vec(cross3(md, hp), sd);
    if (ok) ok = unit_vec(cross3(sd, ax), th);
    if (!ok) begin
      sd = '{0, 0, 0};
      th = '{0, 0, 0};
    end
    f.side_x = sd[0][31:0];
    f.side_y = sd[1][31:0];
    f.side_z = sd[2][31:0];
    f.third_x = th[0][31:0];
    f.third_y = th[1][31:0];
    f.third_z = th[2][31:0];
    f.case_taken = kind;
    f.degenerate = !ok;
    return f;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = frames_due.size();

  always @(posedge clk) begin
    frame_t w;
    if (rst) begin
      lim_z = 107;
      sub_z = 10737;
      lim_xy = 64'd11529215046068;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_Z_NEAR_ZERO:  lim_z = cfg_data[30:0];
          REG_Z_SUBSTITUTE: sub_z = cfg_data[30:0];
          REG_XY_SQ_LIMIT:  lim_xy = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) frames_due.push_back(build_frame(in_data));
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("unexpected output transaction");
          errors++;
        end else begin
          w = frames_due.pop_front();
          if (out_data.side_x !== w.side_x) report("side_x", out_data.side_x, w.side_x);
          if (out_data.side_y !== w.side_y) report("side_y", out_data.side_y, w.side_y);
          if (out_data.side_z !== w.side_z) report("side_z", out_data.side_z, w.side_z);
          if (out_data.third_x !== w.third_x) report("third_x", out_data.third_x, w.third_x);
          if (out_data.third_y !== w.third_y) report("third_y", out_data.third_y, w.third_y);
          if (out_data.third_z !== w.third_z) report("third_z", out_data.third_z, w.third_z);
          if (out_data.case_taken !== w.case_taken)
            report("case_taken", out_data.case_taken, w.case_taken);
          if (out_data.degenerate !== w.degenerate)
            report("degenerate", out_data.degenerate, w.degenerate);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_orthonormal_frame_from_axis.sv =====
`default_nettype none

module tb_orthonormal_frame_from_axis;
  import frm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  axis_t in_data = '0;
  logic out_valid, out_ready = 0;
  frame_t out_data;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  bit idling = 1;
  bit hold_req = 0;

  always #1 clk = ~clk;

  orthonormal_frame_from_axis dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[orthonormal_frame_from_axis] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold on request
  initial begin
    int hold, burst;
    hold = 0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 700;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_axis(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid <= 1;
    in_data <= '{axis_x: x, axis_y: y, axis_z: z};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  // valid drops for one cycle before the next write can start
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sd1 <<< 30 : -(32'sd1 <<< 30);
      2: return $signed($urandom_range(0, 400)) - 200;
      3: return $signed($urandom_range(0, 32'h7fff_ffff)) >>> $urandom_range(0, 30);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_axis;
    logic [31:0] x, y, z;
    int sel;
    sel = $urandom_range(0, 9);
    x = rand_comp($urandom_range(0, 4));
    y = rand_comp($urandom_range(0, 4));
    z = rand_comp($urandom_range(0, 4));
    if (sel == 0) z = $signed($urandom_range(0, 300)) - 150;
    if (sel == 1) begin
      x = $signed($urandom_range(0, 8000)) - 4000;
      y = $signed($urandom_range(0, 8000)) - 4000;
    end
    if (sel == 2) begin
      x = 0;
      y = 0;
    end
    if ($urandom_range(0, 3) == 0) x = -x;
    send_axis(x, y, z);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed items at reset settings
    send_axis(0, 0, 0);
    send_axis(32'sd1 <<< 30, 0, 0);
    send_axis(0, 0, 32'sd1 <<< 30);
    send_axis(0, 0, -(32'sd1 <<< 30));
    send_axis(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_axis(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_axis(32'h8000_0000, 32'h7fff_ffff, 1);
    send_axis(32'sd1 <<< 29, -(32'sd1 <<< 29), 50);
    send_axis(0, 0, 50);
    send_axis(12345, 0, 106);
    send_axis(12345, 0, 107);
    send_axis(12345, 0, -107);
    send_axis(1, 1, 32'sd1 <<< 30);
    send_axis(3000000, 1, 32'sd1 <<< 30);
    send_axis(-1, 0, 32'h8000_0000);
    drain;

    // xy bound exactly hit and just missed, zero limit, zero substitute
    write_reg(REG_XY_SQ_LIMIT, 63'd1 << 40);
    send_axis(32'sd1 <<< 20, 0, 5000);
    send_axis((32'sd1 <<< 20) - 1, 0, 5000);
    drain;
    write_reg(REG_XY_SQ_LIMIT, 0);
    write_reg(REG_Z_SUBSTITUTE, 0);
    send_axis(0, 0, 5000);
    send_axis(0, 0, 0);
    send_axis(777, -3, 10);
    drain;
    write_reg(3, $urandom);

    for (int ph = 0; ph < 8; ph++) begin
      drain;
      case (ph)
        0: begin
          write_reg(REG_Z_NEAR_ZERO, 107);
          write_reg(REG_Z_SUBSTITUTE, 10737);
          write_reg(REG_XY_SQ_LIMIT, 63'd11529215046068);
        end
        1: begin
          write_reg(REG_Z_NEAR_ZERO, 31'h7fff_ffff);
          write_reg(REG_Z_SUBSTITUTE, 31'h7fff_ffff);
        end
        2: begin
          write_reg(REG_Z_NEAR_ZERO, 0);
          write_reg(REG_XY_SQ_LIMIT, 63'h7fff_ffff_ffff_ffff);
        end
        3: write_reg(REG_XY_SQ_LIMIT, 0);
        7: begin
          write_reg(REG_Z_NEAR_ZERO, 107);
          write_reg(REG_Z_SUBSTITUTE, 10737);
          write_reg(REG_XY_SQ_LIMIT, 63'd11529215046068);
          idling = 0;
        end
        default: begin
          write_reg(REG_Z_NEAR_ZERO, $urandom_range(0, 5000));
          write_reg(REG_Z_SUBSTITUTE, $urandom);
          write_reg(REG_XY_SQ_LIMIT, {$urandom, $urandom} >> $urandom_range(1, 40));
        end
      endcase
      if (ph == 4) hold_req = 1;
      repeat (245) random_axis;
    end
    drain;

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[orthonormal_frame_from_axis] OK");
    end else begin
      $display("[orthonormal_frame_from_axis] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
